### rtl/jts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_pkg: shared types and constants of the token scanner
// Word formats, token kind codes, scan modes and character classes.
// ----------------------------------------------------------------------------
package jts_pkg;

	localparam int OFFSET_BITS_DEF = 24;
	localparam int LINE_BITS_DEF   = 20;
	localparam int COL_BITS_DEF    = 16;

	localparam logic [2:0] K_EOF   = 3'd0;
	localparam logic [2:0] K_IDENT = 3'd1;
	localparam logic [2:0] K_NUM   = 3'd2;
	localparam logic [2:0] K_STR   = 3'd3;
	localparam logic [2:0] K_PUNCT = 3'd4;
	localparam logic [2:0] K_LINEC = 3'd5;
	localparam logic [2:0] K_BLOCK = 3'd6;
	localparam logic [2:0] K_ERR   = 3'd7;

	localparam logic [1:0] E_NONE  = 2'd0;
	localparam logic [1:0] E_STR   = 2'd1;
	localparam logic [1:0] E_BLOCK = 2'd2;

	localparam logic [3:0] M_IDLE  = 4'd0;
	localparam logic [3:0] M_IDENT = 4'd1;
	localparam logic [3:0] M_INT   = 4'd2;
	localparam logic [3:0] M_FRAC  = 4'd3;
	localparam logic [3:0] M_EXPS  = 4'd4;
	localparam logic [3:0] M_EXPD  = 4'd5;
	localparam logic [3:0] M_PUNCT = 4'd6;
	localparam logic [3:0] M_LINEC = 4'd7;
	localparam logic [3:0] M_BLOCK = 4'd8;
	localparam logic [3:0] M_STR   = 4'd9;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_BSL = 8'h5C;

	typedef struct packed {
		logic [7:0] ch;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [2:0]                 kind;
		logic [1:0]                 err_code;
		logic [LINE_BITS_DEF-1:0]   head_line;
		logic [COL_BITS_DEF-1:0]    head_col;
		logic [LINE_BITS_DEF-1:0]   tail_line;
		logic [COL_BITS_DEF-1:0]    end_col;
		logic [OFFSET_BITS_DEF-1:0] start_offset;
		logic [OFFSET_BITS_DEF-1:0] end_offset;
		logic                       last;
	} out_word_t;

	// Classified byte handed from the front part to the scanner.
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       is_zero;
		logic       digit;
		logic       id_start;
		logic       id_part;
		logic       space;
		logic       pairable;
		logic       quote;
		logic       exp_mark;
		logic       sign;
	} cls_t;

	function automatic logic two_char(input logic [7:0] p, input logic [7:0] c);
		if (c == "=")
			return (p == "=") || (p == "!") || (p == "<") || (p == ">");
		return (p == c) && ((p == "+") || (p == "-") || (p == "&") || (p == "|"));
	endfunction

endpackage

### rtl/jts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_front: byte classifier
// Accepts input words and registers each byte with its character classes.
// ----------------------------------------------------------------------------
module jts_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid,
	output logic            ready,
	input  jts_pkg::in_word_t in_word,
	output logic            cls_valid,
	input  logic            cls_ready,
	output jts_pkg::cls_t   cls
);
	import jts_pkg::*;

	logic  [7:0] c;
	cls_t  nxt;

	assign c = in_word.ch;
	assign ready = !cls_valid || cls_ready;

	always_comb begin
		nxt.ch       = c;
		nxt.fin      = in_word.final_byte;
		nxt.is_zero  = (c == 8'd0);
		nxt.digit    = (c >= "0") && (c <= "9");
		nxt.id_start = (c == "_") || (c == "$") || ((c >= "a") && (c <= "z")) ||
			((c >= "A") && (c <= "Z"));
		nxt.id_part  = nxt.id_start || nxt.digit;
		nxt.space    = (c == " ") || (c == 8'h09) || (c == 8'h0D) || (c == CH_LF);
		nxt.pairable = (c == "/") || (c == "=") || (c == "!") || (c == "<") ||
			(c == ">") || (c == "+") || (c == "-") || (c == "&") || (c == "|");
		nxt.quote    = (c == "\"") || (c == "'");
		nxt.exp_mark = (c == "e") || (c == "E");
		nxt.sign     = (c == "+") || (c == "-");
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid <= 1'b0;
		end else if (ready) begin
			cls_valid <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid) begin
			cls <= nxt;
		end
	end

endmodule

### rtl/jts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_queue: small FIFO between classifier and scanner
// Four entries of classified bytes, one write and one read port.
// ----------------------------------------------------------------------------
module jts_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  jts_pkg::cls_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output jts_pkg::cls_t rd_data
);
	import jts_pkg::*;

	cls_t       mem [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 3'd4);
	assign rd_valid = (cnt_q != 3'd0);
	assign rd_data  = mem[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wr_data;
		end
	end

endmodule

### rtl/jts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_back: scanner state machine and token output
// Consumes one classified byte per cycle while the output buffer has room,
// producing up to three tokens there; it drains one token per cycle on ready.
// ----------------------------------------------------------------------------
module jts_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cls_valid,
	output logic              cls_ready,
	input  jts_pkg::cls_t     cls,
	output logic              valid,
	input  logic              ready,
	output jts_pkg::out_word_t out_word
);
	import jts_pkg::*;

	localparam int OFFSET_BITS = OFFSET_BITS_DEF;
	localparam int LINE_BITS   = LINE_BITS_DEF;
	localparam int COL_BITS    = COL_BITS_DEF;

	typedef struct packed {
		logic [2:0]             kind;
		logic [1:0]             err;
		logic [LINE_BITS-1:0]   sl;
		logic [COL_BITS-1:0]    sc;
		logic [LINE_BITS-1:0]   el;
		logic [COL_BITS-1:0]    ec;
		logic [OFFSET_BITS-1:0] so;
		logic [OFFSET_BITS-1:0] eo;
		logic                   last;
	} tok_t;

	localparam logic [LINE_BITS-1:0]   LMAX = '1;
	localparam logic [COL_BITS-1:0]    CMAX = '1;
	localparam logic [OFFSET_BITS-1:0] OMAX = '1;
	localparam logic [LINE_BITS-1:0]   L_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
	localparam logic [COL_BITS-1:0]    C_ONE = {{(COL_BITS-1){1'b0}}, 1'b1};
	localparam logic [OFFSET_BITS-1:0] O_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

	logic [3:0]             mode_q;
	logic                   dq_q, esc_q, star_q, ended_q;
	logic [7:0]             pend_q;
	logic [LINE_BITS-1:0]   tsl_q, line_q;
	logic [COL_BITS-1:0]    tsc_q, col_q;
	logic [OFFSET_BITS-1:0] tso_q, off_q;

	// Output buffer: up to four tokens, ring of four.
	tok_t       buf_q [4];
	logic [1:0] bwp_q, brp_q;
	logic [2:0] bcnt_q;

	// Next-state working values.
	logic [3:0]             m;
	logic                   dq, esc, star;
	logic [7:0]             pend;
	logic [LINE_BITS-1:0]   tsl, ln;
	logic [COL_BITS-1:0]    tsc, cl;
	logic [OFFSET_BITS-1:0] tso, of;
	tok_t                   t0, t1, t2;
	logic [1:0]             n;
	logic                   en, go, idle_path, adv, closing;
	logic [2:0]             ck;
	logic [1:0]             ce;
	logic [7:0]             c;

	assign c = cls.ch;
	// Room for the worst case of three tokens.
	assign cls_ready = (bcnt_q <= 3'd1) || ((bcnt_q == 3'd2) && ready);
	assign go = cls_valid && cls_ready;

	function automatic tok_t mk(input logic [2:0] k, input logic [1:0] e, input logic l,
		input logic [LINE_BITS-1:0] sl, input logic [COL_BITS-1:0] sc,
		input logic [OFFSET_BITS-1:0] so, input logic [LINE_BITS-1:0] el,
		input logic [COL_BITS-1:0] ec, input logic [OFFSET_BITS-1:0] eo);
		tok_t r;
		r.kind = k; r.err = e; r.last = l;
		r.sl = sl; r.sc = sc; r.so = so; r.el = el; r.ec = ec; r.eo = eo;
		return r;
	endfunction

	always_comb begin
		m = mode_q; dq = dq_q; esc = esc_q; star = star_q; pend = pend_q;
		tsl = tsl_q; tsc = tsc_q; tso = tso_q; ln = line_q; cl = col_q; of = off_q;
		t0 = '0; t1 = '0; t2 = '0; n = 2'd0; en = ended_q;
		idle_path = 1'b0; adv = 1'b0; closing = 1'b0; ck = K_EOF; ce = E_NONE;

		if (!ended_q && !cls.is_zero) begin
			// Continue the open token, or fall through to the idle path.
			case (mode_q)
				M_IDENT: begin
					if (cls.id_part) adv = 1'b1;
					else begin closing = 1'b1; ck = K_IDENT; idle_path = 1'b1; end
				end
				M_INT, M_FRAC: begin
					if (cls.digit) adv = 1'b1;
					else if (c == "." && mode_q == M_INT) begin m = M_FRAC; adv = 1'b1; end
					else if (cls.exp_mark) begin m = M_EXPS; adv = 1'b1; end
					else begin closing = 1'b1; ck = K_NUM; idle_path = 1'b1; end
				end
				M_EXPS: begin
					if (cls.sign || cls.digit) begin m = M_EXPD; adv = 1'b1; end
					else begin closing = 1'b1; ck = K_NUM; idle_path = 1'b1; end
				end
				M_EXPD: begin
					if (cls.digit) adv = 1'b1;
					else begin closing = 1'b1; ck = K_NUM; idle_path = 1'b1; end
				end
				M_PUNCT: begin
					if (pend_q == "/" && c == "/") begin m = M_LINEC; adv = 1'b1; end
					else if (pend_q == "/" && c == "*") begin
						m = M_BLOCK; star = 1'b0; adv = 1'b1;
					end else if (two_char(pend_q, c)) begin
						adv = 1'b1; closing = 1'b1; ck = K_PUNCT;
					end else begin closing = 1'b1; ck = K_PUNCT; idle_path = 1'b1; end
				end
				M_LINEC: begin
					if (c != CH_LF) adv = 1'b1;
					else begin closing = 1'b1; ck = K_LINEC; idle_path = 1'b1; end
				end
				M_BLOCK: begin
					adv = 1'b1;
					if (star_q && c == "/") begin closing = 1'b1; ck = K_BLOCK; end
					else star = (c == "*");
				end
				M_STR: begin
					if (esc_q) begin esc = 1'b0; adv = 1'b1; end
					else if (c == CH_BSL) begin esc = 1'b1; adv = 1'b1; end
					else if (c == CH_LF) begin
						closing = 1'b1; ck = K_ERR; ce = E_STR; idle_path = 1'b1;
					end else begin
						adv = 1'b1;
						if (c == (dq_q ? 8'h22 : 8'h27)) begin closing = 1'b1; ck = K_STR; end
					end
				end
				default: begin m = M_IDLE; idle_path = 1'b1; end
			endcase

			// Advance counters for a byte taken inside a token; a closing
			// token includes it when advance happens before the close.
			if (adv) begin
				if (of != OMAX) of = of + O_ONE;
				if (c == CH_LF) begin
					if (ln != LMAX) ln = ln + L_ONE;
					cl = C_ONE;
				end else if (cl != CMAX) cl = cl + C_ONE;
			end
			if (closing) begin
				t0 = mk(ck, ce, 1'b0, tsl, tsc, tso, ln, cl, of);
				n = 2'd1;
				m = M_IDLE; pend = '0; esc = 1'b0; star = 1'b0;
			end

			if (idle_path) begin
				if (!cls.space) begin
					tsl = ln; tsc = cl; tso = of;
				end
				if (of != OMAX) of = of + O_ONE;
				if (c == CH_LF) begin
					if (ln != LMAX) ln = ln + L_ONE;
					cl = C_ONE;
				end else if (cl != CMAX) cl = cl + C_ONE;
				if (!cls.space) begin
					if (cls.quote) begin
						m = M_STR; dq = (c == 8'h22); esc = 1'b0;
					end else if (cls.id_start) m = M_IDENT;
					else if (cls.digit) m = M_INT;
					else if (cls.pairable) begin m = M_PUNCT; pend = c; end
					else begin
						if (n == 2'd0) t0 = mk(K_PUNCT, E_NONE, 1'b0, tsl, tsc, tso, ln, cl, of);
						else t1 = mk(K_PUNCT, E_NONE, 1'b0, tsl, tsc, tso, ln, cl, of);
						n = n + 2'd1;
						m = M_IDLE; pend = '0; esc = 1'b0; star = 1'b0;
					end
				end
			end
		end

		// End of text: zero byte, or final byte after its handling.
		if (!ended_q && (cls.is_zero || cls.fin)) begin
			ck = K_EOF; ce = E_NONE;
			case (m)
				M_IDENT: ck = K_IDENT;
				M_INT, M_FRAC, M_EXPS, M_EXPD: ck = K_NUM;
				M_PUNCT: ck = K_PUNCT;
				M_LINEC: ck = K_LINEC;
				M_BLOCK: begin ck = K_ERR; ce = E_BLOCK; end
				M_STR: begin ck = K_ERR; ce = E_STR; end
				default: ck = K_EOF;
			endcase
			if (m != M_IDLE) begin
				if (n == 2'd0) t0 = mk(ck, ce, 1'b0, tsl, tsc, tso, ln, cl, of);
				else t1 = mk(ck, ce, 1'b0, tsl, tsc, tso, ln, cl, of);
				n = n + 2'd1;
			end
			m = M_IDLE; pend = '0; esc = 1'b0; star = 1'b0;
			if (cls.is_zero) en = 1'b1;
		end

		if (cls.fin) begin
			case (n)
				2'd0: t0 = mk(K_EOF, E_NONE, 1'b1, ln, cl, of, ln, cl, of);
				2'd1: t1 = mk(K_EOF, E_NONE, 1'b1, ln, cl, of, ln, cl, of);
				default: t2 = mk(K_EOF, E_NONE, 1'b1, ln, cl, of, ln, cl, of);
			endcase
			n = n + 2'd1;
			m = M_IDLE; dq = 1'b0; pend = '0; esc = 1'b0; star = 1'b0;
			tsl = L_ONE; tsc = C_ONE;
			tso = '0; of = '0;
			ln = L_ONE; cl = C_ONE;
			en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; dq_q <= 1'b0; esc_q <= 1'b0; star_q <= 1'b0;
			pend_q <= '0; ended_q <= 1'b0;
			tsl_q <= L_ONE; tsc_q <= C_ONE;
			tso_q <= '0; off_q <= '0;
			line_q <= L_ONE; col_q <= C_ONE;
			bwp_q <= '0; brp_q <= '0; bcnt_q <= '0;
		end else begin
			if (go) begin
				mode_q <= m; dq_q <= dq; esc_q <= esc; star_q <= star; pend_q <= pend;
				ended_q <= en; tsl_q <= tsl; tsc_q <= tsc; tso_q <= tso;
				off_q <= of; line_q <= ln; col_q <= cl;
				bwp_q <= bwp_q + n;
			end
			if (valid && ready) brp_q <= brp_q + 2'd1;
			bcnt_q <= bcnt_q + (go ? {1'b0, n} : 3'd0) - {2'd0, (valid && ready)};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (n >= 2'd1) buf_q[bwp_q]         <= t0;
			if (n >= 2'd2) buf_q[bwp_q + 2'd1]  <= t1;
			if (n == 2'd3) buf_q[bwp_q + 2'd2]  <= t2;
		end
	end

	tok_t h;
	assign h = buf_q[brp_q];
	assign valid = (bcnt_q != 3'd0);

	always_comb begin
		out_word.kind         = h.kind;
		out_word.err_code     = h.err;
		out_word.head_line    = h.sl;
		out_word.head_col     = h.sc;
		out_word.tail_line    = h.el;
		out_word.end_col      = h.ec;
		out_word.start_offset = h.so;
		out_word.end_offset   = h.eo;
		out_word.last         = h.last;
	end

endmodule

### rtl/js_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// js_token_scanner: streaming JavaScript token scanner
// Path: a word's first token comes after the classifier register, the queue
// entry and then the output buffer that the scanner writes. Throughput: one
// byte per cycle while the output buffer has room for three more tokens;
// tokens drain one per cycle while out_ready is high, so words that make
// several tokens can stall the input until the buffer drains.
// Reset: arst_n clears all control state at once; no clearing pass.
// ----------------------------------------------------------------------------
module js_token_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  jts_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output jts_pkg::out_word_t out_data
);
	import jts_pkg::*;

	// The front part classifies each word; the queue lets the classifier keep
	// taking words while the scanner waits on a full output buffer.
	logic fv, fr, qv, qr;
	cls_t fc, qc;

	jts_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .ready(in_ready),
		.in_word(in_data), .cls_valid(fv), .cls_ready(fr), .cls(fc)
	);

	jts_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fc),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qc)
	);

	// The scanner handles one word per cycle while its output buffer has room and writes up to three tokens.
	jts_back u_back (
		.clk(clk), .arst_n(arst_n), .cls_valid(qv), .cls_ready(qr), .cls(qc),
		.valid(out_valid), .ready(out_ready), .out_word(out_data)
	);

endmodule
